@@ rtl/hpmc_pkg.sv @@
// ----------------------------------------------------------------------------
// hpmc_pkg
// Shared types and byte arithmetic for the half-pel motion compensation block.
// ----------------------------------------------------------------------------
package hpmc_pkg;

   localparam int NUM_REF_BYTES = 17;
   localparam int MAX_ROW_BYTES = 16;
   localparam int HALF_ROW_BYTES = 8;
   localparam int REF_BITS = NUM_REF_BYTES * 8;

   typedef struct packed {
      logic        kind;
      logic        half_x;
      logic        half_y;
      logic        average_dest;
      logic        wide;
      logic [63:0] ref_low;
      logic [63:0] ref_high;
      logic [7:0]  ref_extra;
      logic [63:0] dest_low;
      logic [63:0] dest_high;
      logic        last_row;
   } req_type;

   typedef struct packed {
      logic [63:0] out_low;
      logic [63:0] out_high;
      logic        out_last;
   } rsp_type;

   localparam logic KIND_STORE = 1'b0;
   localparam logic KIND_PROCESS = 1'b1;

   function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] sum;
      sum = {1'b0, a} + {1'b0, b} + 9'd1;
      return sum[8:1];
   endfunction

endpackage

@@ rtl/hpmc_row_pred.sv @@
// ----------------------------------------------------------------------------
// hpmc_row_pred
// Combinational prediction of one row from the current and stored reference
// rows, with optional horizontal, vertical and destination averaging.
// ----------------------------------------------------------------------------
module hpmc_row_pred import hpmc_pkg::*; #(
   parameter int ROW_BYTES = 16
) (
   input  req_type               req,
   input  logic [REF_BITS-1:0]   prev_ref,
   output rsp_type               pred
);

   localparam int EFF_BYTES = (ROW_BYTES > MAX_ROW_BYTES) ? MAX_ROW_BYTES :
                              (ROW_BYTES < HALF_ROW_BYTES) ? HALF_ROW_BYTES : ROW_BYTES;

   logic [REF_BITS-1:0]        cur_ref;
   logic [MAX_ROW_BYTES*8-1:0] dest;
   logic [MAX_ROW_BYTES*8-1:0] row;

   assign cur_ref = {req.ref_extra, req.ref_high, req.ref_low};
   assign dest = {req.dest_high, req.dest_low};

   always_comb begin
      logic [7:0] p;
      logic [7:0] q;
      row = '0;
      for (int i = 0; i < MAX_ROW_BYTES; i++) begin
         p = req.half_x ? avg2(cur_ref[i*8 +: 8], cur_ref[(i+1)*8 +: 8])
                        : cur_ref[i*8 +: 8];
         q = req.half_x ? avg2(prev_ref[i*8 +: 8], prev_ref[(i+1)*8 +: 8])
                        : prev_ref[i*8 +: 8];
         if (req.half_y) begin
            p = avg2(q, p);
         end
         if (req.average_dest) begin
            p = avg2(p, dest[i*8 +: 8]);
         end
         if (i < HALF_ROW_BYTES || (req.wide && i < EFF_BYTES)) begin
            row[i*8 +: 8] = p;
         end
      end
   end

   assign pred.out_low = row[63:0];
   assign pred.out_high = row[127:64];
   assign pred.out_last = req.last_row;

endmodule

@@ rtl/half_pel_motion_compensation.sv @@
// ----------------------------------------------------------------------------
// half_pel_motion_compensation
// Half-pel row prediction with one row per word and a stored reference row.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_word (req_type)
//   rsp_      out        rsp_valid/rsp_stall  rsp_word (rsp_type)
//
// One word per cycle while req_stall is low; a taken word passes the input
// register and the row logic into the result register, which drives rsp_valid.
// Store-only words update the reference row and produce no result.
// Reset clears both valid flags and the stored reference row.
// A stalled result holds; the input register still drains store-only words.
// ----------------------------------------------------------------------------
module half_pel_motion_compensation import hpmc_pkg::*; #(
   parameter int ROW_BYTES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   logic                s1_valid_ff, s1_valid_in;
   req_type             s1_req_ff, s1_req_in;
   logic [REF_BITS-1:0] prev_ref_ff, prev_ref_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_word_ff, rsp_word_in;
   rsp_type             pred;
   logic                out_free;
   logic                s1_adv;
   logic                s1_emit;
   logic                req_acc;

   hpmc_row_pred #(
      .ROW_BYTES (ROW_BYTES)
   ) u_row_pred (
      .req      (s1_req_ff),
      .prev_ref (prev_ref_ff),
      .pred     (pred)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_adv = s1_valid_ff && (s1_req_ff.kind == KIND_STORE || out_free);
   assign s1_emit = s1_adv && s1_req_ff.kind == KIND_PROCESS;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_acc = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      s1_req_in = req_acc ? req_word : s1_req_ff;
      prev_ref_in = s1_adv ? {s1_req_ff.ref_extra, s1_req_ff.ref_high, s1_req_ff.ref_low}
                           : prev_ref_ff;
      rsp_valid_in = out_free ? s1_emit : rsp_valid_ff;
      rsp_word_in = s1_emit ? pred : rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_ref_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ref_ff <= prev_ref_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty input register");

   a_rsp_from_process: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(s1_emit))
      else $error("result raised without a processed row");

   a_ref_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(s1_adv)) |-> $stable(prev_ref_ff))
      else $error("reference row changed without an advancing word");

endmodule
